// ===== rtl/cra_pkg.sv =====
// ----------------------------------------------------------------------------
// cra_pkg
// Shared widths, codes and types for the capped rate accrual block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cra_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned AMOUNT_BITS = 64;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned HOLD_W      = 3;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [DATA_W-1:0] AMOUNT_MASK = {DATA_W{1'b1}} >> (DATA_W - AMOUNT_BITS);

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NON_CANON = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BACKWARDS = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RATE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_RATE_DIV   = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAP_LIMIT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_TIME   = 3'd3;
  localparam logic [IDX_W-1:0] REG_START_TIME = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOLD_FLAGS = 3'd5;
  localparam logic [IDX_W-1:0] REG_TIME_MODE  = 3'd6;

  typedef struct packed {
    logic [DATA_W-1:0] rate;
    logic [DATA_W-1:0] rate_div;
    logic [DATA_W-1:0] cap_limit;
    logic [DATA_W-1:0] end_time;
    logic [HOLD_W-1:0] hold_flags;
    logic              time_mode;
    logic              start_ld;
    logic [DATA_W-1:0] start_val;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/cra_addsub.sv =====
// ----------------------------------------------------------------------------
// cra_addsub
// Shared adder/subtractor: a + b or a - b with carry out (no borrow on sub).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cra_addsub (
  input  wire logic [cra_pkg::DATA_W-1:0] a_i,
  input  wire logic [cra_pkg::DATA_W-1:0] b_i,
  input  wire logic                       sub_i,
  output logic      [cra_pkg::DATA_W-1:0] res_o,
  output logic                            cout_o
);

  logic [cra_pkg::DATA_W-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign {cout_o, res_o} = {1'b0, a_i} + {1'b0, b_eff} + {{cra_pkg::DATA_W{1'b0}}, sub_i};

endmodule

`default_nettype wire

// ===== rtl/cra_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cra_cfg_regs
// Configuration register file; start time writes are passed on as a load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cra_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [cra_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [cra_pkg::DATA_W-1:0] cfg_data_i,
  output cra_pkg::cfg_t                   cfg_o
);

  logic [cra_pkg::DATA_W-1:0] rate_q, rate_div_q, cap_limit_q, end_time_q;
  logic [cra_pkg::HOLD_W-1:0] hold_flags_q;
  logic                       time_mode_q;
  logic                       wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= '0;
      rate_div_q   <= cra_pkg::DATA_W'(1);
      cap_limit_q  <= '0;
      end_time_q   <= '0;
      hold_flags_q <= '0;
      time_mode_q  <= 1'b1;
    end else if (wr) begin
      unique case (cfg_index_i)
        cra_pkg::REG_RATE:       rate_q       <= cfg_data_i & cra_pkg::AMOUNT_MASK;
        cra_pkg::REG_RATE_DIV:   rate_div_q   <= cfg_data_i;
        cra_pkg::REG_CAP_LIMIT:  cap_limit_q  <= cfg_data_i & cra_pkg::AMOUNT_MASK;
        cra_pkg::REG_END_TIME:   end_time_q   <= cfg_data_i;
        cra_pkg::REG_HOLD_FLAGS: hold_flags_q <= cfg_data_i[cra_pkg::HOLD_W-1:0];
        cra_pkg::REG_TIME_MODE:  time_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o            = '0;
    cfg_o.rate       = rate_q;
    cfg_o.rate_div   = rate_div_q;
    cfg_o.cap_limit  = cap_limit_q;
    cfg_o.end_time   = end_time_q;
    cfg_o.hold_flags = hold_flags_q;
    cfg_o.time_mode  = time_mode_q;
    cfg_o.start_ld   = wr && (cfg_index_i == cra_pkg::REG_START_TIME);
    cfg_o.start_val  = cfg_data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/capped_rate_accrual.sv =====
// ----------------------------------------------------------------------------
// capped_rate_accrual
// Time based accrual with remainder carry and a total cap, one shared adder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: batch_time_i with in_valid_i; an item is taken when
//   in_stall_o is low. Output channel: status_o and newly_accrued_o with
//   out_valid_o, held until out_stall_i is low. Config writes go through
//   cfg_valid_i / cfg_ready_o (always ready) with cfg_index_i and cfg_data_i,
//   and the user must make them only while the block is idle; the block
//   itself does not enforce this. One 64-bit add/subtract unit does all
//   the arithmetic. An item that accrues runs clamp, elapsed, 64 shift-add
//   multiply steps, 128 restoring divide steps, then cap and update. Items
//   that end on bad settings, backwards time, a hold, zero elapsed time or
//   a reached cap skip the multiply and divide steps and go straight to
//   the result. One item is in flight at a time; in_stall_o stays high
//   until its result has moved into the output register, so a stalled
//   receiver holds the next item at the input. Reset loads the register
//   reset values, clears the accrued sum and the remainder and sets the
//   last accrual time to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module capped_rate_accrual (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [cra_pkg::DATA_W-1:0]   batch_time_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [cra_pkg::STATUS_W-1:0] status_o,
  output logic      [cra_pkg::DATA_W-1:0]   newly_accrued_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [cra_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire logic [cra_pkg::DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned W = cra_pkg::DATA_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLAMP  = 4'd1;
  localparam logic [3:0] S_ELAPSE = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_ROOM   = 4'd5;
  localparam logic [3:0] S_CMP    = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  localparam logic [cra_pkg::CNT_W-1:0] MUL_LAST = cra_pkg::CNT_W'(W - 1);
  localparam logic [cra_pkg::CNT_W-1:0] DIV_LAST = cra_pkg::CNT_W'(2 * W - 1);

  cra_pkg::cfg_t cfg;

  logic [3:0]                    state_q, state_d;
  logic [cra_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [W-1:0]                  time_q, time_d;
  logic [W-1:0]                  eff_q, eff_d;
  logic [2*W-1:0]                num_q, num_d;
  logic [W-1:0]                  rem_q, rem_d;
  logic [W-1:0]                  amt_q, amt_d;
  logic [cra_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic [W-1:0]                  last_q, last_d;
  logic [W-1:0]                  accrued_q, accrued_d;
  logic [W-1:0]                  carry_q, carry_d;
  logic                          out_valid_q, out_valid_d;
  logic [cra_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [W-1:0]                  out_amt_q, out_amt_d;

  logic [W-1:0] add_a, add_b, add_res;
  logic         add_sub, add_cout;
  logic [W-1:0] div_r2;
  logic         div_take, capped, out_free;

  cra_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cra_addsub u_addsub (
    .a_i    (add_a),
    .b_i    (add_b),
    .sub_i  (add_sub),
    .res_o  (add_res),
    .cout_o (add_cout)
  );

  assign div_r2   = {rem_q[W-2:0], num_q[2*W-1]};
  assign div_take = rem_q[W-1] | add_cout;
  assign capped   = (|num_q[2*W-1:W]) | ~add_cout;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // operand selection for the shared unit
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      S_CLAMP: begin
        add_a   = time_q;
        add_b   = last_q;
        add_sub = 1'b1;
      end
      S_ELAPSE: begin
        add_a   = eff_q;
        add_b   = last_q;
        add_sub = 1'b1;
      end
      S_MUL: begin
        add_a = num_q[2*W-1:W];
        add_b = num_q[0] ? cfg.rate : '0;
      end
      S_DIV: begin
        add_a   = div_r2;
        add_b   = cfg.rate_div;
        add_sub = 1'b1;
      end
      S_ROOM: begin
        add_a   = cfg.cap_limit;
        add_b   = accrued_q;
        add_sub = 1'b1;
      end
      S_CMP: begin
        add_a   = amt_q;
        add_b   = num_q[W-1:0];
        add_sub = 1'b1;
      end
      S_ACC: begin
        add_a = accrued_q;
        add_b = amt_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    time_d       = time_q;
    eff_d        = eff_q;
    num_d        = num_q;
    rem_d        = rem_q;
    amt_d        = amt_q;
    res_status_d = res_status_q;
    last_d       = last_q;
    accrued_d    = accrued_q;
    carry_d      = carry_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_status_d = out_status_q;
    out_amt_d    = out_amt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          time_d  = batch_time_i;
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        eff_d        = ((cfg.end_time != '0) && (time_q > cfg.end_time)) ? cfg.end_time
                                                                         : time_q;
        amt_d        = '0;
        res_status_d = cra_pkg::STATUS_OK;
        if ((cfg.rate_div == '0) || !cfg.time_mode) begin
          res_status_d = cra_pkg::STATUS_NON_CANON;
          state_d      = S_DONE;
        end else if (!add_cout) begin
          res_status_d = cra_pkg::STATUS_BACKWARDS;
          state_d      = S_DONE;
        end else begin
          state_d = S_ELAPSE;
        end
      end
      S_ELAPSE: begin
        // end time below last accrual counts as no time gone by
        if (!add_cout || (add_res == '0) || (cfg.hold_flags != '0) ||
            (accrued_q >= cfg.cap_limit)) begin
          state_d = S_DONE;
        end else begin
          // carry in the upper half lands at the bottom after the shifts
          num_d   = {carry_q, add_res};
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        num_d = {add_cout, add_res, num_q[W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = div_take ? add_res : div_r2;
        num_d = {num_q[2*W-2:0], div_take};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_ROOM;
        end
      end
      S_ROOM: begin
        amt_d   = add_res;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (capped) begin
          carry_d = '0;
        end else begin
          amt_d   = num_q[W-1:0];
          carry_d = rem_q;
        end
        state_d = S_ACC;
      end
      S_ACC: begin
        accrued_d = add_res & cra_pkg::AMOUNT_MASK;
        amt_d     = amt_q & cra_pkg::AMOUNT_MASK;
        last_d    = eff_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_amt_d    = amt_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg.start_ld) begin
      last_d = cfg.start_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      last_q      <= '0;
      accrued_q   <= '0;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      accrued_q   <= accrued_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q       <= time_d;
    eff_q        <= eff_d;
    num_q        <= num_d;
    rem_q        <= rem_d;
    amt_q        <= amt_d;
    res_status_q <= res_status_d;
    out_status_q <= out_status_d;
    out_amt_q    <= out_amt_d;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign newly_accrued_o = out_amt_q;

  // the kept remainder is always below the divisor
  a_carry_below_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |=> (carry_q < cfg.rate_div))
    else $error("carried remainder not below the divisor");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result appeared without a finished item");

  a_div_then_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == DIV_LAST) |=> (state_q == S_ROOM))
    else $error("divide sequence did not end after its last step");

  a_error_zero_amount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != cra_pkg::STATUS_OK) |-> (out_amt_q == '0))
    else $error("nonzero amount with error status");

endmodule

`default_nettype wire
